[sv/chrt_pkg.sv]
package chrt_pkg;

  // field widths
  localparam int unsigned OpW     = 2;
  localparam int unsigned IdW     = 32;
  localparam int unsigned StatusW = 3;

  // operation codes
  localparam logic [OpW-1:0] OP_ADD    = 2'd0;
  localparam logic [OpW-1:0] OP_REMOVE = 2'd1;
  localparam logic [OpW-1:0] OP_LOOKUP = 2'd2;

  // status codes
  localparam logic [StatusW-1:0] ST_OK        = 3'd0;
  localparam logic [StatusW-1:0] ST_BAD_ID    = 3'd1;
  localparam logic [StatusW-1:0] ST_FULL      = 3'd2;
  localparam logic [StatusW-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [StatusW-1:0] ST_EMPTY     = 3'd4;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
    logic out_free;
  } stat_t;

endpackage

[sv/chrt_in_if.sv]
interface chrt_in_if;
  import chrt_pkg::*;

  logic               valid;
  logic               ready;
  logic [OpW-1:0]     op;
  logic [IdW-1:0]     node_id;
  logic [IdW-1:0]     key;

  modport source (output valid, output op, output node_id, output key, input ready);
  modport sink (input valid, input op, input node_id, input key, output ready);
endinterface

[sv/chrt_out_if.sv]
interface chrt_out_if;
  import chrt_pkg::*;

  logic               valid;
  logic               ready;
  logic [IdW-1:0]     owner_id;
  logic [StatusW-1:0] status;

  modport source (output valid, output owner_id, output status, input ready);
  modport sink (input valid, input owner_id, input status, output ready);
endinterface

[sv/chrt_ram.sv]
module chrt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule

[sv/chrt_ctrl.sv]
module chrt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  chrt_pkg::stat_t st,
  output chrt_pkg::cmd_t  cmd
);
  import chrt_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (st.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end
endmodule

[sv/chrt_dp.sv]
module chrt_dp #(
  parameter int unsigned MAX_NODES = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  chrt_pkg::cmd_t                  cmd,
  output chrt_pkg::stat_t                 st,
  input  logic [chrt_pkg::OpW-1:0]        in_op,
  input  logic [chrt_pkg::IdW-1:0]        in_node_id,
  input  logic [chrt_pkg::IdW-1:0]        in_key,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [chrt_pkg::IdW-1:0]        out_owner_id,
  output logic [chrt_pkg::StatusW-1:0]    out_status
);
  import chrt_pkg::*;

  localparam int unsigned IW = $clog2(MAX_NODES);
  localparam int unsigned CW = $clog2(MAX_NODES + 1);

  // latched request
  logic [OpW-1:0] op_r;
  logic [IdW-1:0] node_id_r;
  logic [IdW-1:0] key_r;

  // scan pipeline
  logic [IW-1:0]  idx_r;
  logic           rd_v_r;
  logic [IW-1:0]  rd_idx_r;
  logic [IdW-1:0] rdata;

  // scan accumulators
  logic           found_r;
  logic [IW-1:0]  found_idx_r;
  logic           free_v_r;
  logic [IW-1:0]  free_idx_r;
  logic           any_r;
  logic [IdW-1:0] smallest_r;
  logic           above_r;
  logic [IdW-1:0] best_r;

  // table state
  logic [MAX_NODES-1:0] slot_valid_r;
  logic [CW-1:0]        count_r;

  // output register
  logic               out_valid_r;
  logic [IdW-1:0]     out_owner_r;
  logic [StatusW-1:0] out_status_r;

  // result of the finished scan
  logic [IdW-1:0]     res_owner;
  logic [StatusW-1:0] res_status;
  logic               do_add;
  logic               do_remove;
  logic               full;

  chrt_ram #(
    .WIDTH (IdW),
    .DEPTH (MAX_NODES)
  ) u_ids (
    .clk   (clk),
    .we    (do_add),
    .waddr (free_idx_r),
    .wdata (node_id_r),
    .raddr (idx_r),
    .rdata (rdata)
  );

  assign st.scan_last = (idx_r == IW'(MAX_NODES - 1));
  assign st.out_free  = !out_valid_r || out_ready;

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= in_op;
      node_id_r <= in_node_id;
      key_r     <= in_key;
    end
  end

  // address counter and read tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
    end else begin
      rd_v_r <= cmd.scan;
    end
    rd_idx_r <= idx_r;
    if (cmd.load) begin
      idx_r <= '0;
    end else if (cmd.scan) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  // accumulate over occupied and free slots
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      found_r  <= 1'b0;
      free_v_r <= 1'b0;
      any_r    <= 1'b0;
      above_r  <= 1'b0;
    end else if (rd_v_r) begin
      if (slot_valid_r[rd_idx_r]) begin
        if (rdata == node_id_r) begin
          found_r     <= 1'b1;
          found_idx_r <= rd_idx_r;
        end
        if (!any_r || rdata < smallest_r) begin
          smallest_r <= rdata;
        end
        any_r <= 1'b1;
        if (rdata > key_r && (!above_r || rdata < best_r)) begin
          best_r  <= rdata;
          above_r <= 1'b1;
        end
      end else if (!free_v_r) begin
        free_v_r   <= 1'b1;
        free_idx_r <= rd_idx_r;
      end
    end
  end

  assign full = (count_r == CW'(MAX_NODES));

  // status and owner from the accumulators
  always_comb begin
    res_owner  = '0;
    res_status = ST_OK;
    do_add     = 1'b0;
    do_remove  = 1'b0;
    case (op_r)
      OP_ADD: begin
        if (node_id_r == '0 || found_r) begin
          res_status = ST_BAD_ID;
        end else if (full || !free_v_r) begin
          res_status = ST_FULL;
        end else begin
          do_add = cmd.finish;
        end
      end
      OP_REMOVE: begin
        if (node_id_r == '0 || !found_r) begin
          res_status = ST_NOT_FOUND;
        end else begin
          do_remove = cmd.finish;
        end
      end
      OP_LOOKUP: begin
        if (!any_r) begin
          res_status = ST_EMPTY;
        end else begin
          res_owner = above_r ? best_r : smallest_r;
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  // slot occupancy and node count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
      count_r      <= '0;
    end else if (do_add) begin
      slot_valid_r[free_idx_r] <= 1'b1;
      count_r                  <= count_r + 1'b1;
    end else if (do_remove) begin
      slot_valid_r[found_idx_r] <= 1'b0;
      count_r                   <= count_r - 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.finish) begin
      out_owner_r  <= res_owner;
      out_status_r <= res_status;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_owner_id = out_owner_r;
  assign out_status   = out_status_r;
endmodule

[sv/consistent_hash_ring_table.sv]
// a request is latched when accepted; the id table is then scanned and drained, and the
// result goes to the output register once that is free; no new request is taken until then
//   (the scan reads one entry per cycle through the single read port of the id memory)
// the finished result waits in an output register while the next request is taken
// reset clears the slot-valid bits, node count, controller and output valid;
//   the id memory is not cleared, entries are only read behind their valid bit
module consistent_hash_ring_table #(
  parameter int unsigned MAX_NODES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  chrt_in_if.sink     in_chan,
  chrt_out_if.source  out_chan
);
  import chrt_pkg::*;

  cmd_t  cmd;
  stat_t st;
  logic  in_ready;

  // sequencer
  chrt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // table, scan and result register
  chrt_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .st           (st),
    .in_op        (in_chan.op),
    .in_node_id   (in_chan.node_id),
    .in_key       (in_chan.key),
    .out_valid    (out_chan.valid),
    .out_ready    (out_chan.ready),
    .out_owner_id (out_chan.owner_id),
    .out_status   (out_chan.status)
  );

  assign in_chan.ready = in_ready;
endmodule
